/* rtl/brf_pkg.sv */
// Shared types, constants and request formats of the byte ring FIFO with peek.
`default_nettype none
package brf_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned LVL_W     = 9;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned OFF_W     = 8;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned BYTE_W    = 8;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  typedef struct packed {
    action_e              action;
    logic [BYTE_W-1:0]    data_byte;
    logic                 burst_first;
    logic [LEN_W-1:0]     length;
    logic [OFF_W-1:0]     offset;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    byte_out;
    logic                 byte_valid;
    logic                 last;
    logic                 accepted;
    logic [LVL_W-1:0]     level;
    logic [LVL_W-1:0]     free_space;
    logic                 is_empty;
    logic                 is_full;
    logic [CNT_W-1:0]     dropped_last_write;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [PTR_W-1:0]     waddr;
    logic [BYTE_W-1:0]    wdata;
    logic                 re;
    logic [PTR_W-1:0]     raddr;
  } ram_req_t;

endpackage
`default_nettype wire

/* rtl/byte_ring_fifo_with_peek.sv */
// Top level of the byte ring FIFO with peek: controller plus storage RAM.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   in_req_i  (brf_pkg::in_t)
//   out      output     out_valid_o / out_ready_i out_rsp_o (brf_pkg::out_t)
//   cfg      input      cfg_we_i (no wait)        cfg_wdata_i
//
// A write, clear or empty read or peek request is answered from the result register,
// so such requests follow each other every cycle while results are taken.
// A read or peek of n bytes delivers one byte per cycle while results are taken and
// holds the input until its last byte moves from the pending stage to the result.
// Reset clears pointers, level and counters at once; storage needs no clearing.
// A stalled result holds the next RAM read in its pending stage until it moves.
`default_nettype none
module byte_ring_fifo_with_peek (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire brf_pkg::in_t                 in_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output brf_pkg::out_t                     out_rsp_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [brf_pkg::LVL_W-1:0]    cfg_wdata_i
);

  brf_pkg::ram_req_t               ram_req;
  logic [brf_pkg::BYTE_W-1:0]      ram_rdata;

  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  brf_ram #(
    .DATA_W (brf_pkg::BYTE_W),
    .ADDR_W (brf_pkg::PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire

/* rtl/brf_ram.sv */
// Simple dual-port storage RAM with one write port and a registered read port.
`default_nettype none
module brf_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/brf_ctrl.sv */
// Pointer, level and overflow control with the burst sequencer and result register.
`default_nettype none
module brf_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire brf_pkg::in_t                 in_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output brf_pkg::out_t                     out_rsp_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [brf_pkg::LVL_W-1:0]    cfg_wdata_i,
  output brf_pkg::ram_req_t                 ram_o,
  input  wire logic [brf_pkg::BYTE_W-1:0]   ram_rdata_i
);

  localparam int unsigned PW = brf_pkg::PTR_W;
  localparam int unsigned LW = brf_pkg::LVL_W;
  localparam int unsigned NW = brf_pkg::LEN_W;
  localparam int unsigned CW = brf_pkg::CNT_W;

  brf_pkg::state_e state_q, state_d;
  logic [LW-1:0]   cap_q, cap_d;
  logic [PW-1:0]   wp_q, wp_d;
  logic [PW-1:0]   rp_q, rp_d;
  logic [PW-1:0]   pk_q, pk_d;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic [CW-1:0]   ovf_q, ovf_d;
  logic [CW-1:0]   drops_q, drops_d;
  logic [NW-1:0]   rem_q, rem_d;
  logic            is_peek_q, is_peek_d;
  logic            pend_q, pend_d;
  logic            pend_last_q, pend_last_d;
  logic [LW-1:0]   pend_lvl_q, pend_lvl_d;
  logic            out_vld_q, out_vld_d;
  brf_pkg::out_t   out_q, out_d;

  logic            accept;
  logic            out_free;
  logic            out_load_pend;
  logic [NW-1:0]   len_sat;
  logic [LW-1:0]   off_ext;
  logic [LW-1:0]   pk_diff;
  logic [NW-1:0]   rd_n;
  logic [NW-1:0]   pk_n;
  logic [LW-1:0]   pk_sum;
  logic [PW-1:0]   pk_start;
  logic [CW-1:0]   drops_base;
  logic [LW-1:0]   cap_sat;
  logic [PW-1:0]   burst_addr;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [LW-1:0] cap);
    logic [LW-1:0] nxt;
    nxt = LW'(p) + LW'(1);
    return (nxt >= cap) ? '0 : nxt[PW-1:0];
  endfunction

  function automatic brf_pkg::out_t pack(input logic [brf_pkg::BYTE_W-1:0] b,
                                         input logic valid, input logic last,
                                         input logic acc, input logic [LW-1:0] lvl,
                                         input logic [LW-1:0] cap,
                                         input logic [CW-1:0] ovf);
    brf_pkg::out_t r;
    r.byte_out           = b;
    r.byte_valid         = valid;
    r.last               = last;
    r.accepted           = acc;
    r.level              = lvl;
    r.free_space         = cap - lvl;
    r.is_empty           = (lvl == '0);
    r.is_full            = (lvl == cap);
    r.dropped_last_write = ovf;
    return r;
  endfunction

  assign out_free      = !out_vld_q || out_ready_i;
  assign out_load_pend = pend_q && out_free;
  assign in_ready_o    = (state_q == brf_pkg::ST_IDLE) && !pend_q && out_free;
  assign accept        = in_valid_i && in_ready_o;

  assign len_sat  = (in_req_i.length > NW'(brf_pkg::MAX_BURST)) ?
                    NW'(brf_pkg::MAX_BURST) : in_req_i.length;
  assign off_ext  = LW'(in_req_i.offset);
  assign pk_diff  = lvl_q - off_ext;
  assign rd_n     = (lvl_q < LW'(len_sat)) ? lvl_q[NW-1:0] : len_sat;
  assign pk_n     = (off_ext < lvl_q) ?
                    ((pk_diff < LW'(len_sat)) ? pk_diff[NW-1:0] : len_sat) : '0;
  assign pk_sum   = LW'(rp_q) + off_ext;
  assign pk_start = (pk_sum >= cap_q) ? PW'(pk_sum - cap_q) : pk_sum[PW-1:0];
  assign drops_base = in_req_i.burst_first ? '0 : drops_q;
  assign burst_addr = is_peek_q ? pk_q : rp_q;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_sat = LW'(1);
    end else if (cfg_wdata_i > LW'(brf_pkg::DEPTH)) begin
      cap_sat = LW'(brf_pkg::DEPTH);
    end else begin
      cap_sat = cfg_wdata_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    pk_d        = pk_q;
    lvl_d       = lvl_q;
    ovf_d       = ovf_q;
    drops_d     = drops_q;
    rem_d       = rem_q;
    is_peek_d   = is_peek_q;
    pend_d      = pend_q && !out_load_pend;
    pend_last_d = pend_last_q;
    pend_lvl_d  = pend_lvl_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    ram_o.we    = 1'b0;
    ram_o.waddr = wp_q;
    ram_o.wdata = in_req_i.data_byte;
    ram_o.re    = 1'b0;
    ram_o.raddr = rp_q;

    if (out_load_pend) begin
      out_vld_d = 1'b1;
      out_d     = pack(ram_rdata_i, 1'b1, pend_last_q, 1'b0, pend_lvl_q, cap_q, ovf_q);
    end

    unique case (state_q)
      brf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_req_i.action)
            brf_pkg::ACT_WRITE: begin
              out_vld_d = 1'b1;
              drops_d   = drops_base;
              if (lvl_q < cap_q) begin
                ram_o.we = 1'b1;
                wp_d     = adv(wp_q, cap_q);
                lvl_d    = lvl_q + LW'(1);
                out_d    = pack('0, 1'b0, 1'b1, 1'b1, lvl_q + LW'(1), cap_q, ovf_q);
              end else begin
                if (drops_base != '1) begin
                  drops_d = drops_base + CW'(1);
                end
                ovf_d = drops_d;
                out_d = pack('0, 1'b0, 1'b1, 1'b0, lvl_q, cap_q, drops_d);
              end
            end
            brf_pkg::ACT_READ: begin
              if (rd_n == '0) begin
                out_vld_d = 1'b1;
                out_d     = pack('0, 1'b0, 1'b1, 1'b0, lvl_q, cap_q, ovf_q);
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = rp_q;
                rp_d        = adv(rp_q, cap_q);
                lvl_d       = lvl_q - LW'(1);
                pend_d      = 1'b1;
                pend_last_d = (rd_n == NW'(1));
                pend_lvl_d  = lvl_q - LW'(1);
                rem_d       = rd_n - NW'(1);
                is_peek_d   = 1'b0;
                if (rd_n != NW'(1)) begin
                  state_d = brf_pkg::ST_BURST;
                end
              end
            end
            brf_pkg::ACT_PEEK: begin
              if (pk_n == '0) begin
                out_vld_d = 1'b1;
                out_d     = pack('0, 1'b0, 1'b1, 1'b0, lvl_q, cap_q, ovf_q);
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = pk_start;
                pk_d        = adv(pk_start, cap_q);
                pend_d      = 1'b1;
                pend_last_d = (pk_n == NW'(1));
                pend_lvl_d  = lvl_q;
                rem_d       = pk_n - NW'(1);
                is_peek_d   = 1'b1;
                if (pk_n != NW'(1)) begin
                  state_d = brf_pkg::ST_BURST;
                end
              end
            end
            brf_pkg::ACT_CLEAR: begin
              wp_d      = '0;
              rp_d      = '0;
              lvl_d     = '0;
              ovf_d     = '0;
              drops_d   = '0;
              out_vld_d = 1'b1;
              out_d     = pack('0, 1'b0, 1'b1, 1'b0, '0, cap_q, '0);
            end
            default: begin
            end
          endcase
        end
      end
      brf_pkg::ST_BURST: begin
        if (!pend_q || out_load_pend) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = burst_addr;
          pend_d      = 1'b1;
          pend_last_d = (rem_q == NW'(1));
          rem_d       = rem_q - NW'(1);
          if (is_peek_q) begin
            pk_d       = adv(pk_q, cap_q);
            pend_lvl_d = lvl_q;
          end else begin
            rp_d       = adv(rp_q, cap_q);
            lvl_d      = lvl_q - LW'(1);
            pend_lvl_d = lvl_q - LW'(1);
          end
          if (rem_q == NW'(1)) begin
            state_d = brf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = brf_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      cap_d   = cap_sat;
      wp_d    = '0;
      rp_d    = '0;
      lvl_d   = '0;
      ovf_d   = '0;
      drops_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= brf_pkg::ST_IDLE;
      cap_q     <= LW'(brf_pkg::DEPTH);
      wp_q      <= '0;
      rp_q      <= '0;
      pk_q      <= '0;
      lvl_q     <= '0;
      ovf_q     <= '0;
      drops_q   <= '0;
      rem_q     <= '0;
      is_peek_q <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_q     <= cap_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      pk_q      <= pk_d;
      lvl_q     <= lvl_d;
      ovf_q     <= ovf_d;
      drops_q   <= drops_d;
      rem_q     <= rem_d;
      is_peek_q <= is_peek_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_last_q <= pend_last_d;
    pend_lvl_q  <= pend_lvl_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

/* rtl/brf_checker.sv */
// Port-level assertions for the byte ring FIFO with peek and their bind.
`default_nettype none
module brf_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire brf_pkg::in_t                 in_req_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire brf_pkg::out_t                out_rsp_o,
  input wire logic                         cfg_we_i,
  input wire logic [brf_pkg::LVL_W-1:0]    cfg_wdata_i
);

  logic unused_in;
  assign unused_in = in_valid_i ^ in_ready_o ^ (^in_req_i) ^ cfg_we_i ^ (^cfg_wdata_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("Result changed while stalled.");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.is_empty == (out_rsp_o.level == '0)) &&
                    (out_rsp_o.is_full == (out_rsp_o.free_space == '0)))
    else $error("Status flags disagree with level and free space.");

  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.byte_valid |-> out_rsp_o.last && out_rsp_o.byte_out == '0)
    else $error("A result without a byte is not a final zero result.");

  a_byte_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.byte_valid |-> !out_rsp_o.accepted)
    else $error("A delivered byte is marked as stored.");

endmodule

bind byte_ring_fifo_with_peek brf_checker u_brf_checker (.*);
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the byte ring FIFO with peek, with its own ring model.
module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  brf_pkg::in_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  brf_pkg::out_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic [brf_pkg::LVL_W-1:0] cfg_wdata_i = '0;

  brf_pkg::in_t requests_to_send[$];
  brf_pkg::out_t fifo_results_due[$];

  logic [brf_pkg::BYTE_W-1:0] ring_mem [brf_pkg::DEPTH];
  int ring_wr;
  int ring_rd;
  int ring_level;
  int ring_cap;
  int ovf_count;
  int burst_drop;

  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_total = 0;
  int hold_done = 0;

  byte_ring_fifo_with_peek dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  function automatic int next_slot(input int p);
    return (p + 1 >= ring_cap) ? 0 : p + 1;
  endfunction

  task automatic empty_ring();
    ring_wr = 0;
    ring_rd = 0;
    ring_level = 0;
    ovf_count = 0;
    burst_drop = 0;
  endtask

  task automatic push_rsp(input logic [brf_pkg::BYTE_W-1:0] b, input logic valid,
                          input logic last, input logic acc);
    brf_pkg::out_t r;
    r.byte_out = b;
    r.byte_valid = valid;
    r.last = last;
    r.accepted = acc;
    r.level = brf_pkg::LVL_W'(ring_level);
    r.free_space = brf_pkg::LVL_W'(ring_cap - ring_level);
    r.is_empty = (ring_level == 0);
    r.is_full = (ring_level >= ring_cap);
    r.dropped_last_write = brf_pkg::CNT_W'(ovf_count);
    fifo_results_due.push_back(r);
  endtask

  task automatic ring_fifo_step(input brf_pkg::in_t req);
    int n;
    int len;
    int off;
    int idx;
    logic acc;
    logic [brf_pkg::BYTE_W-1:0] b;
    n = 0;
    acc = 1'b0;
    len = int'(req.length);
    off = int'(req.offset);
    if (len > brf_pkg::MAX_BURST) len = brf_pkg::MAX_BURST;
    case (req.action)
      brf_pkg::ACT_WRITE: begin
        if (req.burst_first) burst_drop = 0;
        if (ring_level < ring_cap) begin
          ring_mem[ring_wr] = req.data_byte;
          ring_wr = next_slot(ring_wr);
          ring_level++;
          acc = 1'b1;
        end else begin
          if (burst_drop < 16'hFFFF) burst_drop++;
          ovf_count = burst_drop;
        end
        push_rsp('0, 1'b0, 1'b1, acc);
      end
      brf_pkg::ACT_CLEAR: begin
        empty_ring();
        push_rsp('0, 1'b0, 1'b1, 1'b0);
      end
      brf_pkg::ACT_READ: begin
        n = (ring_level < len) ? ring_level : len;
        for (int i = 0; i < n; i++) begin
          b = ring_mem[ring_rd];
          ring_rd = next_slot(ring_rd);
          ring_level--;
          push_rsp(b, 1'b1, i == n - 1, 1'b0);
        end
      end
      default: begin
        if (off < ring_level) n = (ring_level - off > len) ? len : ring_level - off;
        idx = (ring_rd + off) % ring_cap;
        for (int i = 0; i < n; i++) begin
          push_rsp(ring_mem[idx], 1'b1, i == n - 1, 1'b0);
          idx = next_slot(idx);
        end
      end
    endcase
    if ((req.action == brf_pkg::ACT_READ || req.action == brf_pkg::ACT_PEEK) && n == 0) begin
      push_rsp('0, 1'b0, 1'b1, 1'b0);
    end
  endtask

  task automatic check_result(input brf_pkg::out_t got, input brf_pkg::out_t want);
    if (got.byte_out !== want.byte_out)
      report_mismatch($sformatf("byte_out %0h, expected %0h", got.byte_out, want.byte_out));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch($sformatf("byte_valid %0b, expected %0b", got.byte_valid, want.byte_valid));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    if (got.accepted !== want.accepted)
      report_mismatch($sformatf("accepted %0b, expected %0b", got.accepted, want.accepted));
    if (got.level !== want.level)
      report_mismatch($sformatf("level %0d, expected %0d", got.level, want.level));
    if (got.free_space !== want.free_space)
      report_mismatch($sformatf("free_space %0d, expected %0d", got.free_space, want.free_space));
    if (got.is_empty !== want.is_empty)
      report_mismatch($sformatf("is_empty %0b, expected %0b", got.is_empty, want.is_empty));
    if (got.is_full !== want.is_full)
      report_mismatch($sformatf("is_full %0b, expected %0b", got.is_full, want.is_full));
    if (got.dropped_last_write !== want.dropped_last_write)
      report_mismatch($sformatf("dropped_last_write %0d, expected %0d",
                                got.dropped_last_write, want.dropped_last_write));
  endtask

  function automatic brf_pkg::in_t mk_req(input brf_pkg::action_e act,
                                          input logic [brf_pkg::BYTE_W-1:0] d,
                                          input logic first,
                                          input logic [brf_pkg::LEN_W-1:0] len,
                                          input logic [brf_pkg::OFF_W-1:0] off);
    brf_pkg::in_t r;
    r.action = act;
    r.data_byte = d;
    r.burst_first = first;
    r.length = len;
    r.offset = off;
    return r;
  endfunction

  function automatic brf_pkg::in_t random_req(input brf_pkg::action_e act);
    logic [brf_pkg::LEN_W-1:0] len;
    logic [brf_pkg::OFF_W-1:0] off;
    len = ($urandom_range(9) == 0) ? brf_pkg::LEN_W'($urandom_range(127, 65))
                                   : brf_pkg::LEN_W'($urandom_range(8));
    off = ($urandom_range(7) == 0) ? brf_pkg::OFF_W'($urandom_range(255))
                                   : brf_pkg::OFF_W'($urandom_range(12));
    return mk_req(act, brf_pkg::BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                  len, off);
  endfunction

  task automatic queue_traffic(input int n_items, input int burst_max);
    int left;
    int k;
    int count;
    brf_pkg::in_t req;
    left = n_items;
    while (left > 0) begin
      k = $urandom_range(99);
      if (k < 45) begin
        count = $urandom_range(burst_max, 1);
        for (int j = 0; j < count && left > 0; j++) begin
          req = random_req(brf_pkg::ACT_WRITE);
          req.burst_first = (j == 0) && ($urandom_range(7) != 0);
          requests_to_send.push_back(req);
          left--;
        end
      end else begin
        if (k < 70) req = random_req(brf_pkg::ACT_READ);
        else if (k < 95) req = random_req(brf_pkg::ACT_PEEK);
        else req = random_req(brf_pkg::ACT_CLEAR);
        requests_to_send.push_back(req);
        left--;
      end
    end
  endtask

  task automatic settle();
    while (requests_to_send.size() != 0 || in_valid_i || fifo_results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [brf_pkg::LVL_W-1:0] cap_value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap_value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ring_cap = (cap_value == 0) ? 1 :
               (int'(cap_value) > brf_pkg::DEPTH) ? brf_pkg::DEPTH : int'(cap_value);
    empty_ring();
  endtask

  task automatic run_phase(input logic [brf_pkg::LVL_W-1:0] cap_value, input int sidle,
                           input int rstall, input int n_items, input int burst_max,
                           input int hold_cycles);
    settle();
    write_capacity(cap_value);
    @(negedge clk_i);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    hold_total = hold_done + hold_cycles;
    queue_traffic(n_items, burst_max);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i <= requests_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_done < hold_total) begin
      hold_done <= hold_done + 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) ring_fifo_step(in_req_i);
      if (out_valid_o && out_ready_i) begin
        if (fifo_results_due.size() == 0) begin
          report_mismatch("result arrived with none expected");
        end else begin
          check_result(out_rsp_o, fifo_results_due.pop_front());
        end
      end
    end
  end

  initial begin
    foreach (ring_mem[i]) ring_mem[i] = '0;
    ring_cap = brf_pkg::DEPTH;
    empty_ring();
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    requests_to_send.push_back(mk_req(brf_pkg::ACT_READ, 8'h00, 1'b0, 7'd5, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_PEEK, 8'h00, 1'b0, 7'd3, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h00, 1'b1, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'hFF, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'hA5, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h5A, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_PEEK, 8'h00, 1'b0, 7'd2, 8'd1));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_PEEK, 8'h00, 1'b0, 7'd127, 8'd3));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_PEEK, 8'hFF, 1'b1, 7'd64, 8'd255));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_READ, 8'h00, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_READ, 8'h00, 1'b0, 7'd1, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_PEEK, 8'h00, 1'b0, 7'd64, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_CLEAR, 8'h00, 1'b1, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_READ, 8'h00, 1'b0, 7'd64, 8'd0));
    settle();

    write_capacity(9'd2);
    @(negedge clk_i);
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h11, 1'b1, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h22, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h33, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h44, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_PEEK, 8'h00, 1'b0, 7'd1, 8'd1));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h55, 1'b1, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_READ, 8'h00, 1'b0, 7'd127, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h66, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h77, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_READ, 8'h00, 1'b0, 7'd1, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_WRITE, 8'h88, 1'b0, 7'd0, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_PEEK, 8'h00, 1'b0, 7'd2, 8'd0));
    requests_to_send.push_back(mk_req(brf_pkg::ACT_CLEAR, 8'h00, 1'b0, 7'd0, 8'd0));

    run_phase(9'd511, 0, 0, 30, 24, 0);
    run_phase(9'd7, 58, 0, 30, 10, 0);
    run_phase(9'd0, 0, 58, 20, 4, 0);
    run_phase(9'd33, 12, 12, 30, 36, 0);
    run_phase(9'd256, 0, 0, 25, 12, 300);

    settle();
    repeat (16) @(negedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
